// File: hdl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and codes for the array list engine: operation and status
// codes, cell commands, controller states and the result record.
// ----------------------------------------------------------------------------
package ale_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_DELALL = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_ROTATE = 3'd3,
        CELL_SORT   = 3'd4
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_ROTATE = 3'd1,
        S_SORT   = 3'd2,
        S_FINISH = 3'd3,
        S_HOLD   = 3'd4
    } t_state;

    typedef struct packed {
        t_cell_cmd  cmd;
        logic [6:0] pos;
        logic       phase;
    } t_cell_ctl;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [5:0]  found_position;
        logic [31:0] read_value;
        logic [6:0]  entry_count;
        logic [6:0]  removed_count;
    } t_result;

endpackage

// File: hdl/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed words kept in a chain of cells, with insert,
// delete, search, delete-all-equal and read operations.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   operation, value, position
//   out      output     o_out_valid / i_out_stall status, found, found_position,
//                                                 read_value, entry_count,
//                                                 removed_count
//
// Insert, delete, errors and unused codes finish when accepted; the result is registered.
// Search and read: accept, one full ring rotation, finish.
// Delete-all: accept, one full ring rotation, CAPACITY odd-even passes, finish.
// Synchronous reset clears the count; entries need no clearing pass.
// A stalled output holds one result; a second finished result waits inside
// and no new transfer is taken until it moves to the output register.
// ----------------------------------------------------------------------------
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic [6:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [5:0]         o_found_position,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_entry_count,
    output logic [6:0]         o_removed_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [IW-1:0] STEP_LAST = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(CAPACITY);

    t_state                r_state, n_state;
    logic [IW-1:0]         r_step, n_step;
    logic [CW-1:0]         r_count, n_count;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [6:0]            r_pos, n_pos;
    logic                  r_found, n_found;
    logic [5:0]            r_fpos, n_fpos;
    logic [31:0]           r_rval, n_rval;
    logic [CW-1:0]         r_hits, n_hits;
    t_result               r_out, r_stage, w_res;
    logic                  r_out_valid;
    logic                  w_res_done;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_match;
    logic [DATA_WIDTH-1:0] w_word;
    logic [PW-1:0]         w_pos_x, w_cnt_x;
    t_cell_ctl             w_ctl;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic                  w_hole [CAPACITY];

    assign w_word     = DATA_WIDTH'(i_value);
    assign w_pos_x    = PW'(i_position);
    assign w_cnt_x    = PW'(r_count);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_match    = (CW'(r_step) < r_count) && (w_data[0] == r_word);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data, w_right_data;
        logic                  w_left_hole, w_right_hole;

        if (g == 0) begin : g_first
            assign w_left_data = '0;
            assign w_left_hole = 1'b0;
        end else begin : g_inner_left
            assign w_left_data = w_data[g-1];
            assign w_left_hole = w_hole[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_data = w_data[0];
            assign w_right_hole = w_match;
        end else begin : g_inner_right
            assign w_right_data = w_data[g+1];
            assign w_right_hole = w_hole[g+1];
        end

        ale_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CAPACITY   (CAPACITY),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_word       (w_word),
            .i_left_data  (w_left_data),
            .i_left_hole  (w_left_hole),
            .i_right_data (w_right_data),
            .i_right_hole (w_right_hole),
            .o_data       (w_data[g]),
            .o_hole       (w_hole[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_count    = r_count;
        n_op       = r_op;
        n_word     = r_word;
        n_pos      = r_pos;
        n_found    = r_found;
        n_fpos     = r_fpos;
        n_rval     = r_rval;
        n_hits     = r_hits;
        w_ctl      = '{cmd: CELL_HOLD, pos: i_position, phase: r_step[0]};
        w_res      = '{status: ST_OK, found: 1'b0, found_position: '0,
                       read_value: '0, entry_count: '0, removed_count: '0};
        w_res_done = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = t_op'(i_operation);
                    n_word  = w_word;
                    n_pos   = i_position;
                    n_step  = '0;
                    n_found = 1'b0;
                    n_fpos  = '0;
                    n_rval  = '0;
                    n_hits  = '0;
                    case (i_operation)
                        OP_INSERT: begin
                            w_res_done = 1'b1;
                            if (r_count >= COUNT_MAX) begin
                                w_res.status = ST_FULL;
                            end else if (w_pos_x > w_cnt_x) begin
                                w_res.status = ST_RANGE;
                            end else begin
                                w_ctl.cmd = CELL_INSERT;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            w_res_done = 1'b1;
                            if (r_count == '0) begin
                                w_res.status = ST_EMPTY;
                            end else if (w_pos_x > w_cnt_x) begin
                                w_res.status = ST_RANGE;
                            end else begin
                                w_ctl.cmd           = CELL_DELETE;
                                n_count             = r_count - 1'b1;
                                w_res.removed_count = 7'd1;
                            end
                        end
                        OP_SEARCH, OP_DELALL: begin
                            if (r_count == '0) begin
                                w_res_done   = 1'b1;
                                w_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_ROTATE;
                            end
                        end
                        OP_READ: begin
                            if (r_count == '0) begin
                                w_res_done   = 1'b1;
                                w_res.status = ST_EMPTY;
                            end else if (w_pos_x >= w_cnt_x) begin
                                w_res_done   = 1'b1;
                                w_res.status = ST_RANGE;
                            end else begin
                                n_state = S_ROTATE;
                            end
                        end
                        default: begin
                            w_res_done = 1'b1;
                        end
                    endcase
                    w_res.entry_count = 7'(n_count);
                    if (w_res_done && !w_out_free) begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_ROTATE: begin
                w_ctl.cmd = CELL_ROTATE;
                if (w_match && !r_found) begin
                    n_found = 1'b1;
                    n_fpos  = 6'(r_step);
                end
                if (w_match) begin
                    n_hits = r_hits + 1'b1;
                end
                if (PW'(r_step) == PW'(r_pos)) begin
                    n_rval = 32'(w_data[0]);
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = (r_op == OP_DELALL) ? S_SORT : S_FINISH;
                end
            end
            S_SORT: begin
                w_ctl.cmd = CELL_SORT;
                n_step    = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                w_res_done = 1'b1;
                case (r_op)
                    OP_SEARCH: begin
                        w_res.found          = r_found;
                        w_res.found_position = r_fpos;
                    end
                    OP_DELALL: begin
                        n_count             = r_count - r_hits;
                        w_res.removed_count = 7'(r_hits);
                    end
                    OP_READ: begin
                        w_res.read_value = r_rval;
                    end
                    default: begin
                        w_res.status = ST_OK;
                    end
                endcase
                w_res.entry_count = 7'(n_count);
                n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_word  <= n_word;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_fpos  <= n_fpos;
        r_rval  <= n_rval;
        r_hits  <= n_hits;
        if (w_res_done && !w_out_free) begin
            r_stage <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_HOLD && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_done && w_out_free) begin
            r_out <= w_res;
        end else if (r_state == S_HOLD && w_out_free) begin
            r_out <= r_stage;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found          = r_out.found;
    assign o_found_position = r_out.found_position;
    assign o_read_value     = r_out.read_value;
    assign o_entry_count    = r_out.entry_count;
    assign o_removed_count  = r_out.removed_count;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("list count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_INSERT && r_count < COUNT_MAX
            && w_pos_x <= w_cnt_x)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not advance the count");

    a_rotate_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROTATE && r_step != STEP_LAST) |=> r_state == S_ROTATE)
        else $error("rotation ended early");

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD |-> r_out_valid)
        else $error("held result with free output register");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_op == OP_DELALL) |-> r_hits <= r_count)
        else $error("more matches than entries");
`endif

endmodule

// File: hdl/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell
// One list slot: holds an entry and its hole mark, and takes the new word or
// data from its left or right neighbor for insert, delete, ring rotation and
// the odd-even compaction passes.
// ----------------------------------------------------------------------------
module ale_cell
    import ale_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 64,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_left_hole,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_hole,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hole
);

    localparam bit ODD_CELL   = (INDEX % 2) == 1;
    localparam bit FIRST_CELL = (INDEX == 0);
    localparam bit LAST_CELL  = (INDEX == CAPACITY - 1);

    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_hole, n_hole;
    logic                  w_pair_right;

    assign w_pair_right = (ODD_CELL == i_ctl.phase);

    always_comb begin
        n_data = r_data;
        n_hole = r_hole;
        case (i_ctl.cmd)
            CELL_INSERT: begin
                if (INDEX > int'(i_ctl.pos)) begin
                    n_data = i_left_data;
                end else if (INDEX == int'(i_ctl.pos)) begin
                    n_data = i_word;
                end
            end
            CELL_DELETE: begin
                if (INDEX >= int'(i_ctl.pos)) begin
                    n_data = i_right_data;
                end
            end
            CELL_ROTATE: begin
                n_data = i_right_data;
                n_hole = i_right_hole;
            end
            CELL_SORT: begin
                if (w_pair_right) begin
                    if (!LAST_CELL && r_hole && !i_right_hole) begin
                        n_data = i_right_data;
                        n_hole = i_right_hole;
                    end
                end else begin
                    if (!FIRST_CELL && i_left_hole && !r_hole) begin
                        n_data = i_left_data;
                        n_hole = i_left_hole;
                    end
                end
            end
            default: begin
                n_data = r_data;
                n_hole = r_hole;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hole <= n_hole;
    end

    assign o_data = r_data;
    assign o_hole = r_hole;

endmodule
